// ===== src/teae_pkg.sv =====
// shared types and constants for the typed edge activation engine
`timescale 1ns / 1ps
`default_nettype none
package teae_pkg;
  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 8192;
  localparam int TOP_COUNT = 5;
  localparam int NODE_AW = $clog2(MAX_NODES);
  localparam int NODE_CW = $clog2(MAX_NODES + 1);
  localparam int EDGE_AW = $clog2(MAX_EDGES);
  localparam int EDGE_CW = $clog2(MAX_EDGES + 1);
  localparam int ROUND_W = $clog2(TOP_COUNT + 1);
  localparam int VAL_W = 16;
  localparam int EDGE_W = 30;
  localparam logic [VAL_W-1:0] EMIT_FLOOR = 16'd76;
  localparam logic [VAL_W-1:0] PROP_FLOOR = 16'd2;
  localparam logic [7:0] COEF_SEQ = 8'd77;
  localparam logic [7:0] COEF_POS = 8'd205;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_ADD  = 2'd1,
    OP_PROP = 2'd2,
    OP_EMIT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_SEQ  = 2'd0,
    KIND_SIM  = 2'd1,
    KIND_POS  = 2'd2,
    KIND_ABST = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    AS_NPTR,
    AS_SRC,
    AS_DST,
    AS_IDX,
    AS_BEST
  } act_sel_t;

  typedef enum logic [1:0] {
    WS_ZERO,
    WS_VAL,
    WS_SUM
  } wr_sel_t;

  typedef enum logic [1:0] {
    OK_RESP,
    OK_PEND,
    OK_PEND_LAST,
    OK_NOHIT
  } out_kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET,
    ST_ADD,
    ST_PSTART,
    ST_PEDGE,
    ST_PSRC,
    ST_PDST,
    ST_MSTART,
    ST_MSCAN,
    ST_MDONE,
    ST_MFIN
  } state_t;

  typedef struct packed {
    logic      clear;
    logic      capture;
    logic      add_exec;
    logic      eptr_inc;
    act_sel_t  act_sel;
    logic      act_we;
    wr_sel_t   wr_sel;
    logic      gain_ld;
    logic      scan_start;
    logic      scan_step;
    logic      pend_ld;
    logic      out_load;
    out_kind_t out_kind;
    logic      out_acc;
  } cmd_t;

  typedef struct packed {
    logic free;
    logic clear_last;
    logic set_ok;
    logic add_ok;
    logic eptr_done;
    logic edge_ok;
    logic v_ok;
    logic scan_done;
    logic found;
    logic pend_vld;
    logic round_last;
  } status_t;
endpackage
`default_nettype wire

// ===== src/teae_ctrl.sv =====
// controller state machine sequencing set, add, propagate and emit
`timescale 1ns / 1ps
`default_nettype none
module teae_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_operation,
  output logic                   in_stall,
  input  wire teae_pkg::status_t st,
  output teae_pkg::cmd_t         cmd
);
  teae_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= teae_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.act_sel = teae_pkg::AS_NPTR;
    cmd.wr_sel = teae_pkg::WS_ZERO;
    cmd.out_kind = teae_pkg::OK_RESP;
    in_stall = (state_r != teae_pkg::ST_IDLE);
    case (state_r)
      teae_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        cmd.act_we = 1'b1;
        if (st.clear_last) state_nxt = teae_pkg::ST_IDLE;
      end
      teae_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (teae_pkg::op_t'(in_operation))
            teae_pkg::OP_SET:  state_nxt = teae_pkg::ST_SET;
            teae_pkg::OP_ADD:  state_nxt = teae_pkg::ST_ADD;
            teae_pkg::OP_PROP: state_nxt = teae_pkg::ST_PSTART;
            default:           state_nxt = teae_pkg::ST_MSTART;
          endcase
        end
      end
      teae_pkg::ST_SET: begin
        if (st.free) begin
          cmd.act_sel = teae_pkg::AS_IDX;
          cmd.wr_sel = teae_pkg::WS_VAL;
          cmd.act_we = st.set_ok;
          cmd.out_load = 1'b1;
          cmd.out_acc = st.set_ok;
          state_nxt = teae_pkg::ST_IDLE;
        end
      end
      teae_pkg::ST_ADD: begin
        if (st.free) begin
          cmd.add_exec = st.add_ok;
          cmd.out_load = 1'b1;
          cmd.out_acc = st.add_ok;
          state_nxt = teae_pkg::ST_IDLE;
        end
      end
      teae_pkg::ST_PSTART: begin
        if (st.eptr_done) begin
          if (st.free) begin
            cmd.out_load = 1'b1;
            cmd.out_acc = 1'b1;
            state_nxt = teae_pkg::ST_IDLE;
          end
        end else begin
          state_nxt = teae_pkg::ST_PEDGE;
        end
      end
      teae_pkg::ST_PEDGE: begin
        if (st.edge_ok) begin
          cmd.act_sel = teae_pkg::AS_SRC;
          state_nxt = teae_pkg::ST_PSRC;
        end else begin
          cmd.eptr_inc = 1'b1;
          state_nxt = teae_pkg::ST_PSTART;
        end
      end
      teae_pkg::ST_PSRC: begin
        if (st.v_ok) begin
          cmd.gain_ld = 1'b1;
          cmd.act_sel = teae_pkg::AS_DST;
          state_nxt = teae_pkg::ST_PDST;
        end else begin
          cmd.eptr_inc = 1'b1;
          state_nxt = teae_pkg::ST_PSTART;
        end
      end
      teae_pkg::ST_PDST: begin
        cmd.act_sel = teae_pkg::AS_DST;
        cmd.wr_sel = teae_pkg::WS_SUM;
        cmd.act_we = 1'b1;
        cmd.eptr_inc = 1'b1;
        state_nxt = teae_pkg::ST_PSTART;
      end
      teae_pkg::ST_MSTART: begin
        cmd.scan_start = 1'b1;
        state_nxt = teae_pkg::ST_MSCAN;
      end
      teae_pkg::ST_MSCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_done) state_nxt = teae_pkg::ST_MDONE;
      end
      teae_pkg::ST_MDONE: begin
        if (st.found) begin
          if (!st.pend_vld || st.free) begin
            cmd.out_load = st.pend_vld;
            cmd.out_kind = teae_pkg::OK_PEND;
            cmd.act_sel = teae_pkg::AS_BEST;
            cmd.act_we = 1'b1;
            cmd.pend_ld = 1'b1;
            state_nxt = st.round_last ? teae_pkg::ST_MFIN : teae_pkg::ST_MSTART;
          end
        end else if (st.free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = st.pend_vld ? teae_pkg::OK_PEND_LAST : teae_pkg::OK_NOHIT;
          state_nxt = teae_pkg::ST_IDLE;
        end
      end
      teae_pkg::ST_MFIN: begin
        if (st.free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = teae_pkg::OK_PEND_LAST;
          state_nxt = teae_pkg::ST_IDLE;
        end
      end
      default: state_nxt = teae_pkg::ST_IDLE;
    endcase
  end

  a_clear_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == teae_pkg::ST_CLEAR) |-> in_stall)
    else $error("input taken during clearing pass");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> st.free)
    else $error("result loaded over a waiting beat");
  a_emit_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pend_ld |-> st.found)
    else $error("pick taken without a found node");
endmodule
`default_nettype wire

// ===== src/teae_dp.sv =====
// datapath: node and edge memories, gain unit, scan compare and result register
`timescale 1ns / 1ps
`default_nettype none
module teae_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire teae_pkg::cmd_t               cmd,
  output teae_pkg::status_t                 st,
  input  wire logic [9:0]                   in_node_index,
  input  wire logic [15:0]                  in_node_value,
  input  wire logic [9:0]                   in_edge_source,
  input  wire logic [9:0]                   in_edge_dest,
  input  wire logic [1:0]                   in_edge_kind,
  input  wire logic [7:0]                   in_edge_score,
  input  wire logic                         cfg_we,
  input  wire logic [10:0]                  cfg_wdata,
  output logic [10:0]                       cfg_active_nodes,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [9:0]                        out_index,
  output logic [15:0]                       out_value,
  output logic                              out_hit,
  output logic                              out_accepted,
  output logic                              out_last
);
  localparam int NA = teae_pkg::NODE_AW;
  localparam int NC = teae_pkg::NODE_CW;
  localparam int EA = teae_pkg::EDGE_AW;
  localparam int EC = teae_pkg::EDGE_CW;
  localparam int VW = teae_pkg::VAL_W;

  logic [VW-1:0] act_mem [teae_pkg::MAX_NODES];
  logic [teae_pkg::EDGE_W-1:0] edge_mem [teae_pkg::MAX_EDGES];

  logic [NC-1:0] active_nodes_r;
  logic [EC-1:0] edge_total_r, eptr_r;
  logic [NC-1:0] nptr_r;
  logic [9:0] idx_r, src_r, dst_r;
  logic [VW-1:0] val_r;
  logic [1:0] kind_r;
  logic [7:0] score_r;
  logic [teae_pkg::EDGE_W-1:0] edge_rd_r;
  logic [VW-1:0] act_rd_r, gain_r, best_r, pend_val_r;
  logic [NA-1:0] best_id_r, pend_id_r, cmp_idx_r;
  logic found_r, cmp_vld_r, pend_vld_r;
  logic [teae_pkg::ROUND_W-1:0] round_r;
  logic out_valid_r, out_hit_r, out_acc_r, out_last_r;
  logic [9:0] out_index_r;
  logic [VW-1:0] out_value_r;

  logic [9:0] e_src, e_dst;
  logic [1:0] e_kind;
  logic [7:0] e_score;
  logic [NA-1:0] act_addr;
  logic [VW-1:0] act_wdata;
  logic [7:0] coef;
  logic [23:0] prod;
  logic [VW-1:0] gain;
  logic [VW:0] sum;
  logic issue, free;

  assign {e_src, e_dst, e_kind, e_score} = edge_rd_r;
  assign free = !out_valid_r || !out_stall;
  assign issue = cmd.scan_step && (nptr_r < active_nodes_r);

  always_comb begin
    case (cmd.act_sel)
      teae_pkg::AS_NPTR: act_addr = nptr_r[NA-1:0];
      teae_pkg::AS_SRC:  act_addr = NA'(e_src);
      teae_pkg::AS_DST:  act_addr = NA'(e_dst);
      teae_pkg::AS_IDX:  act_addr = NA'(idx_r);
      teae_pkg::AS_BEST: act_addr = best_id_r;
      default:           act_addr = nptr_r[NA-1:0];
    endcase
    sum = {1'b0, act_rd_r} + {1'b0, gain_r};
    case (cmd.wr_sel)
      teae_pkg::WS_VAL: act_wdata = val_r;
      teae_pkg::WS_SUM: act_wdata = sum[VW] ? {VW{1'b1}} : sum[VW-1:0];
      default:          act_wdata = '0;
    endcase
    case (teae_pkg::kind_t'(e_kind))
      teae_pkg::KIND_SEQ: coef = teae_pkg::COEF_SEQ;
      teae_pkg::KIND_SIM: coef = e_score;
      teae_pkg::KIND_POS: coef = teae_pkg::COEF_POS;
      default:            coef = '0;
    endcase
    prod = 24'(act_rd_r) * 24'(coef);
    case (teae_pkg::kind_t'(e_kind))
      teae_pkg::KIND_SIM:  gain = {1'b0, prod[23:9]};
      teae_pkg::KIND_ABST: gain = act_rd_r;
      default:             gain = prod[23:8];
    endcase
  end

  always_comb begin
    st.free = free;
    st.clear_last = (nptr_r == NC'(teae_pkg::MAX_NODES - 1));
    st.set_ok = ({{(32-10){1'b0}}, idx_r} < 32'(teae_pkg::MAX_NODES));
    st.add_ok = (NC'(src_r) < active_nodes_r) && (NC'(dst_r) < active_nodes_r) &&
                (edge_total_r < EC'(teae_pkg::MAX_EDGES));
    st.eptr_done = (eptr_r >= edge_total_r);
    st.edge_ok = (NC'(e_src) < active_nodes_r) && (NC'(e_dst) < active_nodes_r);
    st.v_ok = (act_rd_r > teae_pkg::PROP_FLOOR);
    st.scan_done = !issue && !cmp_vld_r;
    st.found = found_r;
    st.pend_vld = pend_vld_r;
    st.round_last = (round_r == teae_pkg::ROUND_W'(teae_pkg::TOP_COUNT - 1));
  end

  always_ff @(posedge clk) begin
    if (cmd.act_we) act_mem[act_addr] <= act_wdata;
    act_rd_r <= act_mem[act_addr];
    if (cmd.add_exec) begin
      edge_mem[edge_total_r[EA-1:0]] <= {src_r, dst_r, kind_r, score_r};
    end
    edge_rd_r <= edge_mem[eptr_r[EA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r <= in_node_index;
      val_r <= in_node_value;
      src_r <= in_edge_source;
      dst_r <= in_edge_dest;
      kind_r <= in_edge_kind;
      score_r <= in_edge_score;
    end
    if (cmd.gain_ld) gain_r <= gain;
    if (cmd.pend_ld) begin
      pend_id_r <= best_id_r;
      pend_val_r <= best_r;
    end
    if (cmd.scan_start) begin
      best_r <= teae_pkg::EMIT_FLOOR;
    end else if (cmd.scan_step && cmp_vld_r && act_rd_r > best_r) begin
      best_r <= act_rd_r;
      best_id_r <= cmp_idx_r;
    end
    cmp_idx_r <= nptr_r[NA-1:0];
    if (cmd.out_load) begin
      case (cmd.out_kind)
        teae_pkg::OK_PEND, teae_pkg::OK_PEND_LAST: begin
          out_index_r <= 10'(pend_id_r);
          out_value_r <= pend_val_r;
        end
        default: begin
          out_index_r <= '0;
          out_value_r <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_nodes_r <= '0;
      edge_total_r <= '0;
      eptr_r <= '0;
      nptr_r <= '0;
      found_r <= 1'b0;
      cmp_vld_r <= 1'b0;
      pend_vld_r <= 1'b0;
      round_r <= '0;
      out_valid_r <= 1'b0;
      out_hit_r <= 1'b0;
      out_acc_r <= 1'b0;
      out_last_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_nodes_r <= ({{(32-11){1'b0}}, cfg_wdata} > 32'(teae_pkg::MAX_NODES)) ?
                          NC'(teae_pkg::MAX_NODES) : NC'(cfg_wdata);
      end
      if (cmd.add_exec) edge_total_r <= edge_total_r + EC'(1);
      if (cmd.capture) begin
        eptr_r <= '0;
        round_r <= '0;
        pend_vld_r <= 1'b0;
      end else begin
        if (cmd.eptr_inc) eptr_r <= eptr_r + EC'(1);
        if (cmd.pend_ld) begin
          round_r <= round_r + teae_pkg::ROUND_W'(1);
          pend_vld_r <= 1'b1;
        end
      end
      if (cmd.clear || issue) nptr_r <= nptr_r + NC'(1);
      else if (cmd.scan_start) nptr_r <= '0;
      cmp_vld_r <= issue;
      if (cmd.scan_start) found_r <= 1'b0;
      else if (cmd.scan_step && cmp_vld_r && act_rd_r > best_r) found_r <= 1'b1;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        case (cmd.out_kind)
          teae_pkg::OK_RESP: begin
            out_hit_r <= 1'b0;
            out_acc_r <= cmd.out_acc;
            out_last_r <= 1'b1;
          end
          teae_pkg::OK_PEND: begin
            out_hit_r <= 1'b1;
            out_acc_r <= 1'b1;
            out_last_r <= 1'b0;
          end
          teae_pkg::OK_PEND_LAST: begin
            out_hit_r <= 1'b1;
            out_acc_r <= 1'b1;
            out_last_r <= 1'b1;
          end
          default: begin
            out_hit_r <= 1'b0;
            out_acc_r <= 1'b1;
            out_last_r <= 1'b1;
          end
        endcase
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign cfg_active_nodes = 11'(active_nodes_r);
  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_value = out_value_r;
  assign out_hit = out_hit_r;
  assign out_accepted = out_acc_r;
  assign out_last = out_last_r;

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edge_total_r <= EC'(teae_pkg::MAX_EDGES))
    else $error("edge count beyond capacity");
  a_hit_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> out_acc_r)
    else $error("picked node without accepted flag");
  a_pick_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> (out_value_r > teae_pkg::EMIT_FLOOR))
    else $error("picked node below emit floor");
endmodule
`default_nettype wire

// ===== src/typed_edge_activation_engine.sv =====
// top level: typed edge activation engine with register port
// set and add return one result each; propagate takes each stored edge through
// edge read, source read, gain and destination update, stopping early on an edge that fails a check
// emit runs up to five rounds, each a scan of the active nodes, one node read per cycle
// after reset a clearing pass zeroes the node store with in_stall high
// reset is synchronous active low; register writes are taken at any time
`timescale 1ns / 1ps
`default_nettype none
module typed_edge_activation_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [9:0]  in_node_index,
  input  wire logic [15:0] in_node_value,
  input  wire logic [9:0]  in_edge_source,
  input  wire logic [9:0]  in_edge_dest,
  input  wire logic [1:0]  in_edge_kind,
  input  wire logic [7:0]  in_edge_score,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [9:0]       out_index,
  output logic [15:0]      out_value,
  output logic             out_hit,
  output logic             out_accepted,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  teae_pkg::cmd_t cmd;
  teae_pkg::status_t st;
  logic cfg_we;
  logic [10:0] active_nodes;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {21'b0, active_nodes} : 32'b0;

  teae_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .st           (st),
    .cmd          (cmd)
  );

  teae_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_node_index    (in_node_index),
    .in_node_value    (in_node_value),
    .in_edge_source   (in_edge_source),
    .in_edge_dest     (in_edge_dest),
    .in_edge_kind     (in_edge_kind),
    .in_edge_score    (in_edge_score),
    .cfg_we           (cfg_we),
    .cfg_wdata        (pwdata[10:0]),
    .cfg_active_nodes (active_nodes),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_index        (out_index),
    .out_value        (out_value),
    .out_hit          (out_hit),
    .out_accepted     (out_accepted),
    .out_last         (out_last)
  );
endmodule
`default_nettype wire
